>>> design/hbscr_pkg.sv
`default_nettype none

package hbscr_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned MV_W     = 14;
  localparam int unsigned IVL_W    = 16;
  localparam int unsigned CD_W     = 18;
  localparam int unsigned PROD_W   = SAMPLE_W + MV_W;
  localparam int unsigned MV_SHIFT = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [MV_W-1:0]  MV_SCALE        = 14'd13300;
  localparam logic [MV_W-1:0]  HYST_MV_RST     = 14'd6000;
  localparam logic [MV_W-1:0]  CENTER_MV_RST   = 14'd5500;
  localparam logic [IVL_W-1:0] BIT_INTERVAL_RST = 16'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HYST     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CENTER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_INTERVAL = 2'd2;

  typedef struct packed {
    logic [MV_W-1:0]  band_mv;
    logic [MV_W-1:0]  center_mv;
    logic [IVL_W-1:0] bit_interval;
  } hbscr_cfg_t;

  typedef struct packed {
    logic emit;
    logic restart;
    logic bit_value;
  } hbscr_tmr_t;

endpackage

`default_nettype wire

>>> design/hbscr_if.sv
`default_nettype none

interface hbscr_in_if;
  logic                               valid;
  logic                               ready;
  logic [hbscr_pkg::SAMPLE_W-1:0]     adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface hbscr_out_if;
  logic valid;
  logic ready;
  logic bit_value;

  modport source (output valid, output bit_value, input ready);
  modport sink   (input valid, input bit_value, output ready);
endinterface

`default_nettype wire

>>> design/hysteresis_bit_slicer_clock_recovery.sv
`default_nettype none

// Hysteresis bit slicer with run-length bit clock recovery. Each transaction on
// in_ch carries one 12-bit converter sample; it is scaled to mV, sliced against
// center_mv with a band of band_mv (half each side) and yields zero or one
// recovered bit on out_ch. A level change restarts bit timing at half of
// bit_interval; otherwise a bit is emitted each time a full interval has elapsed.
// One sample per clock is accepted while out_ch does not stall: a sample is
// registered, then the scaling multiply, both threshold compares and the countdown
// update resolve into the output register as the sample advances. out_ch.valid
// is registered with it. A stall on out_ch holds one sample in the input register
// before in_ch.ready drops. Configuration via cfg_we/cfg_idx/cfg_wdata is to be
// written only while no transaction is in flight; index 3 is ignored.
module hysteresis_bit_slicer_clock_recovery (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  hbscr_in_if.sink                              in_ch,
  hbscr_out_if.source                           out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [hbscr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [hbscr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  hbscr_pkg::hbscr_cfg_t           cfg;
  hbscr_pkg::hbscr_tmr_t           tmr;
  logic                            s1_valid_r;
  logic                            s1_valid_nxt;
  logic [hbscr_pkg::SAMPLE_W-1:0]  s1_sample_r;
  logic                            out_valid_r;
  logic                            out_valid_nxt;
  logic                            out_bit_r;
  logic                            s1_adv;
  logic                            in_acc;
  logic                            level;
  logic                            new_level;

  hbscr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hbscr_slicer u_slicer (
    .adc_sample (s1_sample_r),
    .cfg        (cfg),
    .level      (level),
    .new_level  (new_level)
  );

  hbscr_bit_timer u_timer (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (s1_adv),
    .new_level    (new_level),
    .bit_interval (cfg.bit_interval),
    .level        (level),
    .tmr          (tmr)
  );

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && tmr.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_ch.adc_sample;
    end
    if (s1_adv && tmr.emit) begin
      out_bit_r <= tmr.bit_value;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.bit_value = out_bit_r;

`ifndef SYNTH
  a_rose_needs_adv : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv))
    else $error("result appeared without a sample being processed");

  a_emit_lands : assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && tmr.emit |=> out_valid_r && (out_bit_r == $past(level)))
    else $error("emitted bit not presented at output");

  a_restart_silent : assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && tmr.restart |=> !$rose(out_valid_r))
    else $error("bit emitted on level change");
`endif

endmodule

`default_nettype wire

>>> design/hbscr_cfg_regs.sv
`default_nettype none

module hbscr_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [hbscr_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [hbscr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output hbscr_pkg::hbscr_cfg_t                    cfg
);

  hbscr_pkg::hbscr_cfg_t cfg_r;
  hbscr_pkg::hbscr_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        hbscr_pkg::CFG_IDX_HYST:     cfg_nxt.band_mv      = cfg_wdata[hbscr_pkg::MV_W-1:0];
        hbscr_pkg::CFG_IDX_CENTER:   cfg_nxt.center_mv    = cfg_wdata[hbscr_pkg::MV_W-1:0];
        hbscr_pkg::CFG_IDX_INTERVAL: cfg_nxt.bit_interval = cfg_wdata[hbscr_pkg::IVL_W-1:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.band_mv      <= hbscr_pkg::HYST_MV_RST;
      cfg_r.center_mv    <= hbscr_pkg::CENTER_MV_RST;
      cfg_r.bit_interval <= hbscr_pkg::BIT_INTERVAL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> design/hbscr_slicer.sv
`default_nettype none

module hbscr_slicer (
  input  wire logic [hbscr_pkg::SAMPLE_W-1:0] adc_sample,
  input  wire hbscr_pkg::hbscr_cfg_t          cfg,
  input  wire logic                           level,
  output logic                                new_level
);

  logic [hbscr_pkg::PROD_W-1:0] prod;
  logic [hbscr_pkg::MV_W-1:0]   mv;
  logic [hbscr_pkg::MV_W-2:0]   half;
  logic [hbscr_pkg::MV_W:0]     lo_sum;
  logic [hbscr_pkg::MV_W:0]     hi_thr;
  logic                         go_low;
  logic                         go_high;

  // mV = sample * 13300 >> 12
  assign prod   = hbscr_pkg::PROD_W'(adc_sample) * hbscr_pkg::PROD_W'(hbscr_pkg::MV_SCALE);
  assign mv     = prod[hbscr_pkg::PROD_W-1:hbscr_pkg::MV_SHIFT];
  assign half   = cfg.band_mv[hbscr_pkg::MV_W-1:1];

  // diff < -half  <=>  mv + half < centre;  diff > half  <=>  mv > centre + half
  assign lo_sum  = (hbscr_pkg::MV_W+1)'(mv) + (hbscr_pkg::MV_W+1)'(half);
  assign hi_thr  = (hbscr_pkg::MV_W+1)'(cfg.center_mv) + (hbscr_pkg::MV_W+1)'(half);
  assign go_low  = lo_sum < (hbscr_pkg::MV_W+1)'(cfg.center_mv);
  assign go_high = (hbscr_pkg::MV_W+1)'(mv) > hi_thr;

  always_comb begin
    priority if (go_low) begin
      new_level = 1'b0;
    end else if (go_high) begin
      new_level = 1'b1;
    end else begin
      new_level = level;
    end
  end

endmodule

`default_nettype wire

>>> design/hbscr_bit_timer.sv
`default_nettype none

module hbscr_bit_timer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  wire logic                        new_level,
  input  wire logic [hbscr_pkg::IVL_W-1:0] bit_interval,
  output logic                             level,
  output hbscr_pkg::hbscr_tmr_t            tmr
);

  logic                                level_r;
  logic                                level_nxt;
  logic signed [hbscr_pkg::CD_W-1:0]   countdown_r;
  logic signed [hbscr_pkg::CD_W-1:0]   countdown_nxt;
  logic signed [hbscr_pkg::CD_W-1:0]   cd_dec;
  logic signed [hbscr_pkg::CD_W-1:0]   ivl_s;
  logic [hbscr_pkg::IVL_W-1:0]         ivl;

  // zero interval runs as one
  assign ivl    = (bit_interval == '0) ? hbscr_pkg::IVL_W'(1) : bit_interval;
  assign ivl_s  = $signed(hbscr_pkg::CD_W'(ivl));
  assign cd_dec = countdown_r - hbscr_pkg::CD_W'(1);

  assign tmr.restart   = new_level != level_r;
  assign tmr.emit      = !tmr.restart && (cd_dec[hbscr_pkg::CD_W-1] || (cd_dec == '0));
  assign tmr.bit_value = level_r;

  always_comb begin
    level_nxt     = level_r;
    countdown_nxt = countdown_r;
    if (adv) begin
      priority if (tmr.restart) begin
        level_nxt     = new_level;
        countdown_nxt = $signed(hbscr_pkg::CD_W'(ivl[hbscr_pkg::IVL_W-1:1]));
      end else if (tmr.emit) begin
        countdown_nxt = cd_dec + ivl_s;
      end else begin
        countdown_nxt = cd_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= 1'b0;
      countdown_r <= '0;
    end else begin
      level_r     <= level_nxt;
      countdown_r <= countdown_nxt;
    end
  end

  assign level = level_r;

endmodule

`default_nettype wire

>>> tb/hbscr_bit_check.sv
module hbscr_bit_check (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [hbscr_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic                             out_bit,
  input  logic                             cfg_we,
  input  logic [hbscr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [hbscr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                               bits_pending,
  output int                               bit_errors
);
  timeunit 1ns;
  timeprecision 1ps;

  hbscr_pkg::hbscr_cfg_t             regs;
  logic                              level_q;
  logic signed [hbscr_pkg::CD_W-1:0] countdown_q;
  logic                              bits_due[$];
  int                                err_cnt = 0;

  function automatic int sample_to_mv(logic [hbscr_pkg::SAMPLE_W-1:0] s);
    logic [hbscr_pkg::PROD_W-1:0] prod;
    prod = hbscr_pkg::PROD_W'(s) * hbscr_pkg::PROD_W'(hbscr_pkg::MV_SCALE);
    return int'(prod >> hbscr_pkg::MV_SHIFT);
  endfunction

  task automatic slice_sample(logic [hbscr_pkg::SAMPLE_W-1:0] s);
    int   mv;
    int   centre;
    int   diff;
    int   half;
    int   ivl;
    logic nxt;
    mv     = sample_to_mv(s);
    centre = int'(regs.center_mv);
    diff   = mv - centre;
    half   = int'(regs.band_mv >> 1);
    ivl    = (regs.bit_interval == '0) ? 1 : int'(regs.bit_interval);
    nxt    = level_q;
    if (diff < -half) nxt = 1'b0;
    else if (diff > half) nxt = 1'b1;
    countdown_q = countdown_q - hbscr_pkg::CD_W'(1);
    if (nxt != level_q) begin
      level_q     = nxt;
      countdown_q = hbscr_pkg::CD_W'(ivl >> 1);
    end else if (countdown_q <= 0) begin
      countdown_q = countdown_q + hbscr_pkg::CD_W'(ivl);
      bits_due.push_back(level_q);
    end
  endtask

  always @(posedge clk) begin
    logic exp_bit;
    if (!rst_n) begin
      regs.band_mv      = hbscr_pkg::HYST_MV_RST;
      regs.center_mv    = hbscr_pkg::CENTER_MV_RST;
      regs.bit_interval = hbscr_pkg::BIT_INTERVAL_RST;
      level_q           = 1'b0;
      countdown_q       = '0;
      bits_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          hbscr_pkg::CFG_IDX_HYST:     regs.band_mv      = cfg_wdata[hbscr_pkg::MV_W-1:0];
          hbscr_pkg::CFG_IDX_CENTER:   regs.center_mv    = cfg_wdata[hbscr_pkg::MV_W-1:0];
          hbscr_pkg::CFG_IDX_INTERVAL: regs.bit_interval = cfg_wdata[hbscr_pkg::IVL_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (bits_due.size() == 0) begin
          $error("bit_value: expected none, actual %0b", out_bit);
          err_cnt++;
        end else begin
          exp_bit = bits_due.pop_front();
          if (exp_bit !== out_bit) begin
            $error("bit_value: expected %0b, actual %0b", exp_bit, out_bit);
            err_cnt++;
          end
        end
      end
      if (in_valid && in_ready) slice_sample(in_sample);
    end
    bits_pending <= bits_due.size();
    bit_errors   <= err_cnt;
  end

endmodule

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [hbscr_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 4;

  typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

  localparam logic [hbscr_pkg::SAMPLE_W-1:0] DIRECTED [23] = '{
    12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
    12'd4095, 12'd2618, 12'd2048, 12'hAAA, 12'h555, 12'd770, 12'd2619,
    12'd769, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd0
  };

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             cfg_we;
  logic [hbscr_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [hbscr_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                               bits_pending;
  int                               bit_errors;
  int                               stall_cycles = 0;
  logic                             hold_req;
  logic                             hold_done = 1'b0;
  int                               burst_left;
  int                               gap_max;
  logic [hbscr_pkg::MV_W-1:0]       hyst_set;
  logic [hbscr_pkg::MV_W-1:0]       center_set;
  logic [hbscr_pkg::IVL_W-1:0]      ivl_set;

  always #4 clk = ~clk;

  hbscr_in_if  in_ch ();
  hbscr_out_if out_ch ();

  hysteresis_bit_slicer_clock_recovery dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  hbscr_bit_check bit_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_sample    (in_ch.adc_sample),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_bit      (out_ch.bit_value),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .bits_pending (bits_pending),
    .bit_errors   (bit_errors)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : receiver
    rx_mode_t mode;
    int       left;
    int       tick;
    out_ch.ready <= 1'b0;
    mode = RX_ALWAYS;
    left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(3, 0));
        left = $urandom_range(200, 30);
      end
      left--;
      tick++;
      case (mode)
        RX_ALWAYS: out_ch.ready <= 1'b1;
        RX_COIN:   out_ch.ready <= 1'($urandom_range(1, 0));
        RX_SPARSE: out_ch.ready <= ($urandom_range(3, 0) == 0);
        default:   out_ch.ready <= (tick % 3 != 0);
      endcase
    end
  end

  task automatic push(logic [hbscr_pkg::SAMPLE_W-1:0] s);
    in_ch.valid      <= 1'b1;
    in_ch.adc_sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic offer(logic [hbscr_pkg::SAMPLE_W-1:0] s);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(gap_max, 0);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(24, 1);
    end
    burst_left--;
    push(s);
  endtask

  // sender pauses until every expected bit is out, then lets the pipeline settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (bits_pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic cfg_write(logic [hbscr_pkg::CFG_IDX_W-1:0] idx,
                           logic [hbscr_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(logic [hbscr_pkg::CFG_DATA_W-1:0] h,
                            logic [hbscr_pkg::CFG_DATA_W-1:0] c,
                            logic [hbscr_pkg::CFG_DATA_W-1:0] i);
    cfg_write(hbscr_pkg::CFG_IDX_HYST, h);
    cfg_write(hbscr_pkg::CFG_IDX_CENTER, c);
    cfg_write(hbscr_pkg::CFG_IDX_INTERVAL, i);
    hyst_set   = h[hbscr_pkg::MV_W-1:0];
    center_set = c[hbscr_pkg::MV_W-1:0];
    ivl_set    = i;
  endtask

  // runs of a clean level around bit-interval multiples, some in-band runs, some noise
  task automatic run_stream(int n);
    int                             ivl;
    int                             half;
    int                             centre;
    int                             hi_s;
    int                             lo_s;
    int                             cnt;
    int                             run;
    int                             kind;
    logic                           bitv;
    logic [hbscr_pkg::SAMPLE_W-1:0] s;
    ivl    = (ivl_set == '0) ? 1 : int'(ivl_set);
    half   = int'(hyst_set >> 1);
    centre = int'(center_set);
    hi_s   = (centre + half) * 4096 / 13300 + 1;
    lo_s   = (centre - half) * 4096 / 13300 - 1;
    if (hi_s > 4095) hi_s = 4095;
    if (lo_s < 0) lo_s = 0;
    cnt = 0;
    while (cnt < n) begin
      kind = $urandom_range(9, 0);
      if (kind == 0) begin
        offer(hbscr_pkg::SAMPLE_W'($urandom_range(4095, 0)));
        cnt++;
      end else begin
        bitv = 1'($urandom_range(1, 0));
        run  = ivl * $urandom_range(3, 1) + $urandom_range(2, 0) - 1;
        if (run < 1) run = 1;
        if (run > 64) run = $urandom_range(64, 16);
        repeat (run) begin
          if (kind == 1) s = hbscr_pkg::SAMPLE_W'($urandom_range(hi_s, lo_s));
          else if (bitv) s = hbscr_pkg::SAMPLE_W'($urandom_range(4095, hi_s));
          else s = hbscr_pkg::SAMPLE_W'($urandom_range(lo_s, 0));
          offer(s);
          cnt++;
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [hbscr_pkg::CFG_DATA_W-1:0] h;
    logic [hbscr_pkg::CFG_DATA_W-1:0] c;
    logic [hbscr_pkg::CFG_DATA_W-1:0] i;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.adc_sample <= '0;
    cfg_we           <= 1'b0;
    cfg_idx          <= hbscr_pkg::CFG_IDX_HYST;
    cfg_wdata        <= '0;
    hold_req   = 1'b0;
    burst_left = 0;
    gap_max    = 0;
    hyst_set   = hbscr_pkg::HYST_MV_RST;
    center_set = hbscr_pkg::CENTER_MV_RST;
    ivl_set    = hbscr_pkg::BIT_INTERVAL_RST;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[k]) offer(DIRECTED[k]);
    drain();

    // zero band, zero centre, zero interval
    set_config(16'd0, 16'd0, 16'd0);
    gap_max = 4;
    run_stream(60);
    drain();
    cfg_write(CFG_IDX_SPARE, 16'h1234);
    run_stream(40);
    drain();

    set_config(16'd13300, 16'd13300, 16'd65535);
    run_stream(60);
    drain();

    // out-of-range writes, upper data bits dropped by the 14-bit registers
    set_config(16'hFFFF, 16'hFFFF, 16'd1);
    run_stream(60);
    drain();

    set_config(16'd2000, 16'd6650, 16'd4);
    gap_max  = 0;
    hold_req = 1'b1;
    run_stream(200);
    drain();
    gap_max = 6;
    run_stream(60);
    drain();
    run_stream(60);
    drain();

    repeat (7) begin
      h = hbscr_pkg::CFG_DATA_W'($urandom_range(13300, 0));
      c = hbscr_pkg::CFG_DATA_W'($urandom_range(13300, 0));
      if ($urandom_range(5, 0) == 0) i = hbscr_pkg::CFG_DATA_W'($urandom_range(65535, 1));
      else i = hbscr_pkg::CFG_DATA_W'($urandom_range(24, 1));
      gap_max = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(8, 1);
      set_config(h, c, i);
      run_stream(110);
      drain();
    end

    repeat (10) @(negedge clk);
    if (bit_errors == 0 && bits_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
